### hdl/xor_checked_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_defines.svh
// Assertion macros of the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define XOR_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define XCFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define XCFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Types and constants of the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = LIMIT_W;
    localparam int FAULT_OUT_W = 32;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [LIMIT_W-1:0]    t_limit;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Register indexes
    localparam t_cfg_idx REG_HEAD_FIRST     = 3'd0;
    localparam t_cfg_idx REG_HEAD_SECOND    = 3'd1;
    localparam t_cfg_idx REG_FUNCTION_LIMIT = 3'd2;
    localparam t_cfg_idx REG_LENGTH_LIMIT   = 3'd3;
    localparam t_cfg_idx REG_TAIL_FIRST     = 3'd4;
    localparam t_cfg_idx REG_TAIL_SECOND    = 3'd5;

    // Reset values of the registers
    localparam t_byte  RST_HEAD_FIRST     = 8'hFC;
    localparam t_byte  RST_HEAD_SECOND    = 8'hFF;
    localparam t_limit RST_FUNCTION_LIMIT = 9'h0F1;
    localparam t_limit RST_LENGTH_LIMIT   = 9'd100;
    localparam t_byte  RST_TAIL_FIRST     = 8'hA1;
    localparam t_byte  RST_TAIL_SECOND    = 8'hA2;

endpackage

`default_nettype wire

### hdl/xor_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Byte-serial frame deframer with header/tail match and XOR checksum.
// ----------------------------------------------------------------------------
// Every received byte yields exactly one result in the cycle after its transfer,
// and a new byte is taken every cycle: the parse step is one small state
// machine update between the byte at the input and the result register, and
// the result register decouples the two sides, so the next byte is taken while
// a result still waits (ready drops only when the result register is full and
// not being taken). Frames are header pair, function byte, length byte,
// payload, checksum byte, tail pair. Any byte that does not fit returns the
// parser to header hunting and bumps the fault counter; a checksum mismatch
// ends the frame with frame_done set and frame_good clear. Configuration
// writes take effect on the next byte and are meant for idle periods.
`default_nettype none

module xor_checked_frame_receiver
    import xcfr_pkg::*;
#(
    parameter int FAULT_COUNTER_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // received bytes
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [BYTE_W-1:0]      i_rx_byte,
    // results
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_payload_valid,
    output logic [BYTE_W-1:0]           o_payload_byte,
    output logic [BYTE_W-1:0]           o_payload_index,
    output logic                        o_frame_done,
    output logic                        o_frame_good,
    output logic [BYTE_W-1:0]           o_function_code,
    output logic [BYTE_W-1:0]           o_payload_length,
    output logic [FAULT_OUT_W-1:0]      o_fault_count
);

    typedef enum logic [2:0] {
        HUNT_HEAD1 = 3'd0,
        HUNT_HEAD2 = 3'd1,
        GET_FUNC   = 3'd2,
        GET_LEN    = 3'd3,
        GET_DATA   = 3'd4,
        GET_CHECK  = 3'd5,
        GET_TAIL1  = 3'd6,
        GET_TAIL2  = 3'd7
    } t_phase;

    // configuration
    t_byte  r_head_first, r_head_second, r_tail_first, r_tail_second;
    t_limit r_function_limit, r_length_limit;

    // parser state
    t_phase r_phase, n_phase;
    t_byte  r_remaining, n_remaining;
    t_byte  r_position, n_position;
    t_byte  r_xor, n_xor;
    t_byte  r_check, n_check;
    t_byte  r_func, n_func;
    t_byte  r_len, n_len;
    logic [FAULT_COUNTER_BITS-1:0] r_fault, n_fault;

    // result register
    logic  r_out_valid;
    logic  r_pv, n_pv;
    t_byte r_pb, n_pb;
    t_byte r_pi, n_pi;
    logic  r_done, n_done;
    logic  r_good, n_good;
    logic [FAULT_OUT_W-1:0] r_fault_out;

    logic fault;
    logic in_xfer;
    logic [FAULT_COUNTER_BITS+FAULT_OUT_W-1:0] fault_ext;

    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_position  = r_position;
        n_xor       = r_xor;
        n_check     = r_check;
        n_func      = r_func;
        n_len       = r_len;
        n_pv        = 1'b0;
        n_pb        = '0;
        n_pi        = '0;
        n_done      = 1'b0;
        n_good      = 1'b0;
        fault       = 1'b0;

        unique case (r_phase)
            HUNT_HEAD1: begin
                if (i_rx_byte == r_head_first) begin
                    n_phase = HUNT_HEAD2;
                    n_xor   = i_rx_byte;
                end else begin
                    fault = 1'b1;
                end
            end
            HUNT_HEAD2: begin
                if (i_rx_byte == r_head_second) begin
                    n_phase = GET_FUNC;
                    n_xor   = r_xor ^ i_rx_byte;
                end else begin
                    fault = 1'b1;
                end
            end
            GET_FUNC: begin
                if ({1'b0, i_rx_byte} < r_function_limit) begin
                    n_phase = GET_LEN;
                    n_func  = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                end else begin
                    fault = 1'b1;
                end
            end
            GET_LEN: begin
                if ({1'b0, i_rx_byte} < r_length_limit) begin
                    n_phase     = GET_DATA;
                    n_len       = i_rx_byte;
                    n_remaining = i_rx_byte;
                    n_position  = '0;
                    n_xor       = r_xor ^ i_rx_byte;
                end else begin
                    fault = 1'b1;
                end
            end
            GET_DATA: begin
                if (r_remaining != '0) begin
                    n_pv        = 1'b1;
                    n_pb        = i_rx_byte;
                    n_pi        = r_position;
                    n_position  = r_position + 8'd1;
                    n_xor       = r_xor ^ i_rx_byte;
                    n_remaining = r_remaining - 8'd1;
                    if (r_remaining == 8'd1) begin
                        n_phase = GET_CHECK;
                    end
                end else begin
                    // zero length: any byte that follows is a fault
                    fault = 1'b1;
                end
            end
            GET_CHECK: begin
                n_check = i_rx_byte;
                n_phase = GET_TAIL1;
            end
            GET_TAIL1: begin
                if (i_rx_byte == r_tail_first) begin
                    n_phase = GET_TAIL2;
                end else begin
                    fault = 1'b1;
                end
            end
            GET_TAIL2: begin
                if (i_rx_byte == r_tail_second) begin
                    n_phase = HUNT_HEAD1;
                    n_done  = 1'b1;
                    n_good  = (r_xor == r_check);
                end else begin
                    fault = 1'b1;
                end
            end
        endcase

        if (fault) begin
            n_phase = HUNT_HEAD1;
            n_fault = r_fault + {{(FAULT_COUNTER_BITS-1){1'b0}}, 1'b1};
        end else begin
            n_fault = r_fault;
        end
    end

    assign fault_ext = {{FAULT_OUT_W{1'b0}}, n_fault};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first     <= RST_HEAD_FIRST;
            r_head_second    <= RST_HEAD_SECOND;
            r_function_limit <= RST_FUNCTION_LIMIT;
            r_length_limit   <= RST_LENGTH_LIMIT;
            r_tail_first     <= RST_TAIL_FIRST;
            r_tail_second    <= RST_TAIL_SECOND;
            r_phase          <= HUNT_HEAD1;
            r_remaining      <= '0;
            r_position       <= '0;
            r_xor            <= '0;
            r_check          <= '0;
            r_func           <= '0;
            r_len            <= '0;
            r_fault          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_HEAD_FIRST:     r_head_first     <= i_cfg_data[BYTE_W-1:0];
                    REG_HEAD_SECOND:    r_head_second    <= i_cfg_data[BYTE_W-1:0];
                    REG_FUNCTION_LIMIT: r_function_limit <= i_cfg_data;
                    REG_LENGTH_LIMIT:   r_length_limit   <= i_cfg_data;
                    REG_TAIL_FIRST:     r_tail_first     <= i_cfg_data[BYTE_W-1:0];
                    REG_TAIL_SECOND:    r_tail_second    <= i_cfg_data[BYTE_W-1:0];
                    default: ;  // drop writes beyond the register list
                endcase
            end

            if (in_xfer) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_position  <= n_position;
                r_xor       <= n_xor;
                r_check     <= n_check;
                r_func      <= n_func;
                r_len       <= n_len;
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pv        <= n_pv;
            r_pb        <= n_pb;
            r_pi        <= n_pi;
            r_done      <= n_done;
            r_good      <= n_good;
            r_fault_out <= fault_ext[FAULT_OUT_W-1:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_payload_valid  = r_pv;
    assign o_payload_byte   = r_pb;
    assign o_payload_index  = r_pi;
    assign o_frame_done     = r_done;
    assign o_frame_good     = r_good;
    assign o_function_code  = r_func;
    assign o_payload_length = r_len;
    assign o_fault_count    = r_fault_out;

endmodule

`default_nettype wire

### hdl/xcfr_checker.sv
// ----------------------------------------------------------------------------
// xcfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_frame_receiver_defines.svh"

module xcfr_checker
    import xcfr_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic              o_payload_valid,
    input wire logic [BYTE_W-1:0] o_payload_byte,
    input wire logic [BYTE_W-1:0] o_payload_index,
    input wire logic              o_frame_done,
    input wire logic              o_frame_good
);

    // a waiting result must hold until its transfer
    `XCFR_ASSERT(a_result_hold, o_valid && !i_ready |=> o_valid && $stable(o_payload_byte) && $stable(o_frame_done), "stalled result changed")

    // a good checksum is only reported on a completed frame
    `XCFR_ASSERT(a_good_needs_done, o_valid && o_frame_good |-> o_frame_done, "frame_good without frame_done")

    // a byte is payload or a frame end, never both
    `XCFR_ASSERT(a_data_or_end, o_valid |-> !(o_payload_valid && o_frame_done), "payload byte ended a frame")

    // non-payload results carry zero byte and index
    `XCFR_ASSERT(a_idle_payload_zero, o_valid && !o_payload_valid |-> o_payload_byte == '0 && o_payload_index == '0, "stale payload fields")

    // reset empties the result register
    `XCFR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_payload_valid (o_payload_valid),
    .o_payload_byte  (o_payload_byte),
    .o_payload_index (o_payload_index),
    .o_frame_done    (o_frame_done),
    .o_frame_good    (o_frame_good)
);

`default_nettype wire
